>>> rtl/plcp_pkg.sv
package plcp_pkg;

  // Character codes used by the command grammar.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_K     = 8'h4B;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_W     = 8'h57;

  // Bit positions in the keyword flags, listed in priority order.
  localparam int KW_STS   = 0;
  localparam int KW_SET   = 1;
  localparam int KW_CHK   = 2;
  localparam int KW_PWD   = 3;
  localparam int KW_ALM   = 4;
  localparam int KW_TMO   = 5;
  localparam int KW_COUNT = 6;

  localparam int TIMEOUT_W  = 6;
  localparam int VALUE_W    = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MAX = 2'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN_RESET    = 6'd5;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX_RESET    = 6'd30;
  localparam logic [TIMEOUT_W-1:0] STORED_TIMEOUT_RESET = 6'd15;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_FAIL = 2'd1,
    REPLY_OK   = 2'd2
  } reply_e;

  typedef struct packed {
    logic                eol;
    logic [KW_COUNT-1:0] keywords;
    logic [VALUE_W-1:0]  value;
    logic                count_exact;
  } scan_info_t;

  typedef struct packed {
    logic                 valid;
    reply_e               reply;
    logic                 open_door;
    logic                 sound_alarm;
    logic [TIMEOUT_W-1:0] timeout_seconds;
  } result_t;

endpackage

>>> rtl/plcp_if.sv
interface plcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface plcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [5:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface plcp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply;
  logic       open_door;
  logic       sound_alarm;
  logic [5:0] timeout_seconds;

  modport source (output valid, output reply, output open_door, output sound_alarm,
                  output timeout_seconds, input ready);
  modport sink (input valid, input reply, input open_door, input sound_alarm,
                input timeout_seconds, output ready);
endinterface

>>> rtl/plcp_line_scan.sv
module plcp_line_scan
  import plcp_pkg::*;
#(
  parameter int LINE_LIMIT      = 32,
  parameter int PASSWORD_DIGITS = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [7:0]                       byte_i,
  output scan_info_t                       info_o,
  output logic [PASSWORD_DIGITS-1:0][3:0]  digits_o
);

  localparam int LW = $clog2(LINE_LIMIT);
  localparam int CW = $clog2(PASSWORD_DIGITS + 2);
  localparam logic [LW-1:0] LEN_LAST = LW'(LINE_LIMIT - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(PASSWORD_DIGITS);

  logic [LW-1:0]                      len_q, len_d;
  logic [2:0][7:0]                    rec_q, rec_d;
  logic [KW_COUNT-1:0]                kw_q, kw_d;
  logic                               colon_q, colon_d;
  logic [CW-1:0]                      cnt_q, cnt_d;
  logic [PASSWORD_DIGITS-1:0][3:0]    dig_q, dig_d;
  logic [VALUE_W-1:0]                 val_q, val_d;

  logic        overflow;
  logic        is_eol;
  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] prod;

  always_comb begin
    overflow = (len_q >= LEN_LAST);
    is_eol   = !overflow && ((byte_i == CHAR_CR) || (byte_i == CHAR_LF));
    is_digit = colon_q && (byte_i >= CHAR_0) && (byte_i <= CHAR_9);
    digit    = byte_i[3:0];
    prod     = ({4'd0, val_q} << 3) + ({4'd0, val_q} << 1) + {8'd0, digit};

    len_d   = len_q + 1'b1;
    kw_d    = kw_q;
    colon_d = colon_q | (byte_i == CHAR_COLON);
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    val_d   = val_q;
    rec_d[2] = rec_q[1];
    rec_d[1] = rec_q[0];
    rec_d[0] = byte_i;

    if (rec_q[1] == CHAR_S && rec_q[0] == CHAR_T && byte_i == CHAR_S) begin
      kw_d[KW_STS] = 1'b1;
    end
    if (rec_q[1] == CHAR_A && rec_q[0] == CHAR_L && byte_i == CHAR_M) begin
      kw_d[KW_ALM] = 1'b1;
    end
    if (byte_i == CHAR_COLON) begin
      if (rec_q[2] == CHAR_S && rec_q[1] == CHAR_E && rec_q[0] == CHAR_T) begin
        kw_d[KW_SET] = 1'b1;
      end
      if (rec_q[2] == CHAR_C && rec_q[1] == CHAR_H && rec_q[0] == CHAR_K) begin
        kw_d[KW_CHK] = 1'b1;
      end
      if (rec_q[2] == CHAR_P && rec_q[1] == CHAR_W && rec_q[0] == CHAR_D) begin
        kw_d[KW_PWD] = 1'b1;
      end
      if (rec_q[2] == CHAR_T && rec_q[1] == CHAR_M && rec_q[0] == CHAR_O) begin
        kw_d[KW_TMO] = 1'b1;
      end
    end

    if (is_digit) begin
      for (int i = 0; i < PASSWORD_DIGITS; i++) begin
        if (cnt_q == CW'(i)) begin
          dig_d[i] = digit;
        end
      end
      // The count stops one past the password length, which is enough to
      // tell "exactly right" from "too many".
      if (cnt_q <= CNT_FULL) begin
        cnt_d = cnt_q + 1'b1;
      end
      val_d = (prod > 12'd255) ? 8'hFF : prod[7:0];
    end

    if (overflow || is_eol) begin
      len_d   = '0;
      rec_d   = '0;
      kw_d    = '0;
      colon_d = 1'b0;
      cnt_d   = '0;
      dig_d   = '0;
      val_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      rec_q   <= '0;
      kw_q    <= '0;
      colon_q <= 1'b0;
      cnt_q   <= '0;
      dig_q   <= '0;
      val_q   <= '0;
    end else if (step_i) begin
      len_q   <= len_d;
      rec_q   <= rec_d;
      kw_q    <= kw_d;
      colon_q <= colon_d;
      cnt_q   <= cnt_d;
      dig_q   <= dig_d;
      val_q   <= val_d;
    end
  end

  assign info_o.eol         = is_eol;
  assign info_o.keywords    = kw_q;
  assign info_o.value       = val_q;
  assign info_o.count_exact = (cnt_q == CNT_FULL);
  assign digits_o           = dig_q;

endmodule

>>> rtl/plcp_action.sv
module plcp_action
  import plcp_pkg::*;
#(
  parameter int PASSWORD_DIGITS = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  scan_info_t                       info_i,
  input  logic [PASSWORD_DIGITS-1:0][3:0]  digits_i,
  input  logic                             cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]           cfg_index_i,
  input  logic [TIMEOUT_W-1:0]             cfg_data_i,
  output result_t                          result_o
);

  logic [PASSWORD_DIGITS-1:0][3:0] pwd_q, pwd_d;
  logic                            present_q, present_d;
  logic [TIMEOUT_W-1:0]            tmo_q, tmo_d;
  logic [TIMEOUT_W-1:0]            tmin_q, tmax_q;
  logic                            match;
  logic                            in_bounds;

  always_comb begin
    match     = info_i.count_exact && (digits_i == pwd_q);
    in_bounds = (info_i.value >= {2'b00, tmin_q}) && (info_i.value <= {2'b00, tmax_q});

    pwd_d     = pwd_q;
    present_d = present_q;
    tmo_d     = tmo_q;

    result_o.valid       = info_i.eol;
    result_o.reply       = REPLY_NONE;
    result_o.open_door   = 1'b0;
    result_o.sound_alarm = 1'b0;

    if (info_i.keywords[KW_STS]) begin
      result_o.reply = present_q ? REPLY_OK : REPLY_FAIL;
    end else if (info_i.keywords[KW_SET]) begin
      // Digits past the count are still clear, which gives the zero padding.
      pwd_d          = digits_i;
      present_d      = 1'b1;
      result_o.reply = REPLY_OK;
    end else if (info_i.keywords[KW_CHK]) begin
      result_o.reply = match ? REPLY_OK : REPLY_FAIL;
    end else if (info_i.keywords[KW_PWD]) begin
      result_o.reply     = match ? REPLY_OK : REPLY_FAIL;
      result_o.open_door = match;
    end else if (info_i.keywords[KW_ALM]) begin
      result_o.sound_alarm = 1'b1;
    end else if (info_i.keywords[KW_TMO]) begin
      if (in_bounds) begin
        tmo_d          = info_i.value[TIMEOUT_W-1:0];
        result_o.reply = REPLY_OK;
      end else begin
        result_o.reply = REPLY_FAIL;
      end
    end else begin
      result_o.valid = 1'b0;
    end

    result_o.timeout_seconds = tmo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwd_q     <= '0;
      present_q <= 1'b0;
      tmo_q     <= STORED_TIMEOUT_RESET;
    end else if (step_i && info_i.eol) begin
      pwd_q     <= pwd_d;
      present_q <= present_d;
      tmo_q     <= tmo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmin_q <= TIMEOUT_MIN_RESET;
      tmax_q <= TIMEOUT_MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT_MIN: tmin_q <= cfg_data_i;
        CFG_TIMEOUT_MAX: tmax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/password_lock_command_parser_core.sv
// Command parser for a password lock, fed one received character at a time.
// rx_i carries characters; a line ends at CR or LF and is then decoded.
// res_o carries one transaction per line that holds a keyword (STS, SET:,
// CHK:, PWD:, ALM, TMO:); other lines and overlong lines give nothing.
// cfg_i writes timeout_min (index 0) and timeout_max (index 1); it is
// always ready and should only be used while no line is in flight.
// Throughput is one character per cycle while res_o does not stall. A character
// taken into the input register is decoded from there, and its result is loaded
// into the output register when that character advances out of the input register.
// The line state and the stored password update at that same advance, so the
// character rate is set by the path from the input register
// through the keyword and digit logic into the output register.
// When res_o stalls, the output register holds its transaction, one more
// character can still be taken while the input register is empty, and then rx_i.ready
// drops until the result is taken.
// Reset empties both registers, clears the line and the password, and loads
// timeout_min 5, timeout_max 30 and a stored timeout of 15.
module password_lock_command_parser_core
  import plcp_pkg::*;
#(
  parameter int LINE_LIMIT      = 32,
  parameter int PASSWORD_DIGITS = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  plcp_byte_if.sink     rx_i,
  plcp_cfg_if.sink      cfg_i,
  plcp_result_if.source res_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic       advance;
  logic       rx_take;

  scan_info_t                      info;
  logic [PASSWORD_DIGITS-1:0][3:0] digits;
  result_t                         result;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready  = !in_valid_q || advance;
  assign rx_take     = rx_i.valid && rx_i.ready;
  assign in_valid_d  = rx_take || (in_valid_q && !advance);
  assign out_valid_d = advance ? result.valid : (out_valid_q && !res_o.ready);
  assign cfg_i.ready = 1'b1;

  plcp_line_scan #(
    .LINE_LIMIT      (LINE_LIMIT),
    .PASSWORD_DIGITS (PASSWORD_DIGITS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .info_o   (info),
    .digits_o (digits)
  );

  plcp_action #(
    .PASSWORD_DIGITS (PASSWORD_DIGITS)
  ) u_action (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .info_i      (info),
    .digits_i    (digits),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (advance && result.valid) begin
      out_q <= result;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.reply           = out_q.reply;
  assign res_o.open_door       = out_q.open_door;
  assign res_o.sound_alarm     = out_q.sound_alarm;
  assign res_o.timeout_seconds = out_q.timeout_seconds;

  // The door only opens on a successful password check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.open_door) |-> (res_o.reply == REPLY_OK))
    else $error("open_door without an ok reply");

  // An alarm transaction carries no reply character and no door command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.sound_alarm) |-> (res_o.reply == REPLY_NONE && !res_o.open_door))
    else $error("alarm result carries a reply or door command");

  // Input backs up only when both registers are full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (in_valid_q && out_valid_q && !res_o.ready))
    else $error("input stalled without a full pipeline");

  // A stalled result stays in the output register into the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result was lost or changed");

endmodule

>>> test/password_lock_command_parser_core_tb.sv
`timescale 1ns / 1ps

module password_lock_command_parser_core_tb;
  import plcp_pkg::*;

  localparam int LINE_LIMIT      = 32;
  localparam int PASSWORD_DIGITS = 5;
  localparam int RANDOM_CHARS    = 840;
  localparam int PHASES          = 6;
  localparam int IDLE_LIMIT      = 500;

  typedef struct {
    reply_e               reply;
    bit                   open_door;
    bit                   sound_alarm;
    bit [TIMEOUT_W-1:0]   timeout;
  } lock_reply_t;

  typedef byte unsigned line_t[$];

  // Tracks the parser state from the accepted characters and queues the
  // reply that each completed command line must produce.
  class lock_scoreboard;
    bit [TIMEOUT_W-1:0] tmo_lo;
    bit [TIMEOUT_W-1:0] tmo_hi;
    bit [TIMEOUT_W-1:0] tmo_stored;
    int unsigned        line_len;
    int unsigned        digit_cnt;
    bit [7:0]           hist [3];
    bit [KW_COUNT-1:0]  kw;
    bit                 colon;
    bit [3:0]           digits [PASSWORD_DIGITS];
    bit [VALUE_W-1:0]   value;
    bit [3:0]           password [PASSWORD_DIGITS];
    bit                 pw_present;
    lock_reply_t        replies_due[$];
    int                 errors;
    int                 checked;
    int                 dropped_lines;
    int                 action_cnt [KW_COUNT];

    function new();
      tmo_lo = TIMEOUT_MIN_RESET;
      tmo_hi = TIMEOUT_MAX_RESET;
      tmo_stored = STORED_TIMEOUT_RESET;
      foreach (password[i]) password[i] = 4'd0;
      pw_present = 1'b0;
      errors = 0;
      checked = 0;
      dropped_lines = 0;
      foreach (action_cnt[i]) action_cnt[i] = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len = 0;
      foreach (hist[i]) hist[i] = 8'd0;
      kw = '0;
      colon = 1'b0;
      digit_cnt = 0;
      foreach (digits[i]) digits[i] = 4'd0;
      value = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [TIMEOUT_W-1:0] data);
      if (idx == CFG_TIMEOUT_MIN) tmo_lo = data;
      else if (idx == CFG_TIMEOUT_MAX) tmo_hi = data;
    endfunction

    function bit digits_match();
      if (digit_cnt != PASSWORD_DIGITS) return 1'b0;
      foreach (digits[i]) if (digits[i] != password[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void scan_char(bit [7:0] b);
      int unsigned v;
      if (hist[1] == CHAR_S && hist[0] == CHAR_T && b == CHAR_S) kw[KW_STS] = 1'b1;
      if (hist[1] == CHAR_A && hist[0] == CHAR_L && b == CHAR_M) kw[KW_ALM] = 1'b1;
      if (b == CHAR_COLON) begin
        if (hist[2] == CHAR_S && hist[1] == CHAR_E && hist[0] == CHAR_T) kw[KW_SET] = 1'b1;
        if (hist[2] == CHAR_C && hist[1] == CHAR_H && hist[0] == CHAR_K) kw[KW_CHK] = 1'b1;
        if (hist[2] == CHAR_P && hist[1] == CHAR_W && hist[0] == CHAR_D) kw[KW_PWD] = 1'b1;
        if (hist[2] == CHAR_T && hist[1] == CHAR_M && hist[0] == CHAR_O) kw[KW_TMO] = 1'b1;
      end
      if (colon && b >= CHAR_0 && b <= CHAR_9) begin
        v = 32'(value) * 10 + 32'(b - CHAR_0);
        if (digit_cnt < PASSWORD_DIGITS) digits[digit_cnt] = 4'(b - CHAR_0);
        if (digit_cnt <= PASSWORD_DIGITS) digit_cnt++;
        value = (v > 255) ? 8'd255 : v[7:0];
      end
      if (b == CHAR_COLON) colon = 1'b1;
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = b;
    endfunction

    function void end_line();
      lock_reply_t r;
      r.reply = REPLY_NONE;
      r.open_door = 1'b0;
      r.sound_alarm = 1'b0;
      if (kw[KW_STS]) begin
        r.reply = pw_present ? REPLY_OK : REPLY_FAIL;
        action_cnt[KW_STS]++;
      end else if (kw[KW_SET]) begin
        for (int i = 0; i < PASSWORD_DIGITS; i++)
          password[i] = (i < digit_cnt) ? digits[i] : 4'd0;
        pw_present = 1'b1;
        r.reply = REPLY_OK;
        action_cnt[KW_SET]++;
      end else if (kw[KW_CHK]) begin
        r.reply = digits_match() ? REPLY_OK : REPLY_FAIL;
        action_cnt[KW_CHK]++;
      end else if (kw[KW_PWD]) begin
        if (digits_match()) begin
          r.reply = REPLY_OK;
          r.open_door = 1'b1;
        end else begin
          r.reply = REPLY_FAIL;
        end
        action_cnt[KW_PWD]++;
      end else if (kw[KW_ALM]) begin
        r.sound_alarm = 1'b1;
        action_cnt[KW_ALM]++;
      end else if (kw[KW_TMO]) begin
        if (value >= tmo_lo && value <= tmo_hi) begin
          tmo_stored = value[TIMEOUT_W-1:0];
          r.reply = REPLY_OK;
        end else begin
          r.reply = REPLY_FAIL;
        end
        action_cnt[KW_TMO]++;
      end else begin
        return;
      end
      r.timeout = tmo_stored;
      replies_due.push_back(r);
    endfunction

    function void take_char(bit [7:0] b);
      // A full line swallows the next character, terminator included.
      if (line_len >= LINE_LIMIT - 1) begin
        clear_line();
        dropped_lines++;
        return;
      end
      line_len++;
      if (b == CHAR_CR || b == CHAR_LF) begin
        end_line();
        clear_line();
      end else begin
        scan_char(b);
      end
    endfunction

    function void check_reply(logic [1:0] reply, logic door, logic alarm,
                              logic [TIMEOUT_W-1:0] tmo);
      lock_reply_t e;
      if (replies_due.size() == 0) begin
        $display({"%0t ERROR unexpected reply: expected none, ",
                  "actual reply %0d door %0d alarm %0d timeout %0d"},
                 $time, reply, door, alarm, tmo);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      checked++;
      if (reply !== e.reply) begin
        $display("%0t ERROR reply: expected %0d, actual %0d", $time, e.reply, reply);
        errors++;
      end
      if (door !== e.open_door) begin
        $display("%0t ERROR open_door: expected %0d, actual %0d", $time, e.open_door, door);
        errors++;
      end
      if (alarm !== e.sound_alarm) begin
        $display("%0t ERROR sound_alarm: expected %0d, actual %0d", $time, e.sound_alarm, alarm);
        errors++;
      end
      if (tmo !== e.timeout) begin
        $display("%0t ERROR timeout_seconds: expected %0d, actual %0d", $time, e.timeout, tmo);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  plcp_byte_if   rx_if ();
  plcp_cfg_if    cfg_if ();
  plcp_result_if res_if ();

  password_lock_command_parser_core #(
    .LINE_LIMIT      (LINE_LIMIT),
    .PASSWORD_DIGITS (PASSWORD_DIGITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  lock_scoreboard sb = new();

  int    chars_sent = 0;
  int    burst_left = 1;
  bit    rx_busy = 1'b0;
  int    bound_writes = 0;
  int    gen_lo = TIMEOUT_MIN_RESET;
  int    gen_hi = TIMEOUT_MAX_RESET;
  string gen_pw = "00000";

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        sb.check_reply(res_if.reply, res_if.open_door, res_if.sound_alarm,
                       res_if.timeout_seconds);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (rx_if.valid && rx_if.ready) sb.take_char(rx_if.rx_byte);
    end
  end

  // Result side: ready follows one of four stall patterns, redrawn at random as the test runs.
  initial begin
    int cyc;
    int mode;
    int hold;
    cyc = 0;
    mode = 0;
    hold = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 300 == 0) mode = $urandom_range(3, 0);
      case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(3, 0) != 0);
        2: res_if.ready <= cyc[0];
        default: begin
          if (hold > 0) begin
            hold--;
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(15, 0) == 0) hold = $urandom_range(12, 2);
          end
        end
      endcase
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready) || !rst_ni)
        idle = 0;
      else
        idle++;
    end
    $display("%0t Watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_char(input byte unsigned b);
    int gap;
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    rx_busy = 1'b1;
    do @(posedge clk_i); while (!rx_if.ready);
    chars_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 0);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        rx_busy = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(64, 32) : $urandom_range(12, 1);
    end
  endtask

  task automatic send_line(input line_t q);
    foreach (q[i]) send_char(q[i]);
  endtask

  function automatic void put_text(ref line_t q, input string s);
    foreach (s[i]) q.push_back(s[i]);
  endfunction

  task automatic say(input string s, input byte unsigned term);
    line_t q;
    put_text(q, s);
    q.push_back(term);
    send_line(q);
  endtask

  // Let every expected reply arrive and the pipeline empty out.
  task automatic quiesce();
    if (rx_busy) begin
      rx_if.valid <= 1'b0;
      rx_busy = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_bounds(input bit [TIMEOUT_W-1:0] lo, input bit [TIMEOUT_W-1:0] hi);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_TIMEOUT_MIN;
    cfg_if.data <= lo;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.index <= CFG_TIMEOUT_MAX;
    cfg_if.data <= hi;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    gen_lo = int'(lo);
    gen_hi = int'(hi);
    bound_writes++;
  endtask

  function automatic string digit_string(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9, 0))};
    return s;
  endfunction

  function automatic string random_junk(int n);
    string alphabet;
    string s;
    int k;
    alphabet = "ABCDEHKLMOPSTW:0123456789 xyz";
    s = "";
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(alphabet.len() - 1, 0);
      s = {s, alphabet.substr(k, k)};
    end
    return s;
  endfunction

  function automatic string pw_guess();
    int r;
    r = $urandom_range(9, 0);
    if (r < 5) return gen_pw;
    if (r < 6) return {gen_pw.substr(0, 1), "-", gen_pw.substr(2, 4)};
    if (r < 8) return digit_string(5);
    return digit_string($urandom_range(7, 0));
  endfunction

  function automatic string tmo_text();
    int r;
    int v;
    r = $urandom_range(9, 0);
    if (r < 4) return $sformatf("%0d", $urandom_range(63, 0));
    if (r < 7) begin
      case ($urandom_range(3, 0))
        0: v = gen_lo - 1;
        1: v = gen_lo;
        2: v = gen_hi;
        default: v = gen_hi + 1;
      endcase
      return $sformatf("%0d", v);
    end
    if (r < 8) return "";
    if (r < 9) return $sformatf("%0d", $urandom_range(99999, 64));
    return $sformatf("%03d", $urandom_range(63, 0));
  endfunction

  function automatic line_t random_command();
    line_t q;
    string s;
    string d;
    string p;
    int op;
    s = "";
    if ($urandom_range(3, 0) == 0) s = random_junk($urandom_range(4, 1));
    // A second keyword in front exercises the priority between keywords.
    if ($urandom_range(9, 0) == 0) begin
      case ($urandom_range(3, 0))
        0: s = {s, "TMO:1 "};
        1: s = {s, "ALM "};
        2: s = {s, "PWD:"};
        default: s = {s, "STS "};
      endcase
    end
    op = $urandom_range(5, 0);
    case (op)
      0: s = {s, "STS"};
      1: begin
        d = digit_string($urandom_range(7, 0));
        s = {s, "SET:", d};
        p = d;
        while (p.len() < PASSWORD_DIGITS) p = {p, "0"};
        gen_pw = p.substr(0, PASSWORD_DIGITS - 1);
      end
      2: s = {s, "CHK:", pw_guess()};
      3: s = {s, "PWD:", pw_guess()};
      4: s = {s, "ALM"};
      default: s = {s, "TMO:", tmo_text()};
    endcase
    if ($urandom_range(4, 0) == 0) s = {s, random_junk($urandom_range(3, 1))};
    put_text(q, s);
    case ($urandom_range(2, 0))
      0: q.push_back(CHAR_CR);
      1: q.push_back(CHAR_LF);
      default: begin
        q.push_back(CHAR_CR);
        q.push_back(CHAR_LF);
      end
    endcase
    return q;
  endfunction

  function automatic line_t random_line();
    line_t q;
    string broken [10];
    int r;
    byte unsigned b;
    broken = '{"SE:1", "CHK12345", "TM:10", "AL M", "S TS", "PWD;12345", "STT",
               "TMO10", "ALSM", "SETT:1"};
    r = $urandom_range(99, 0);
    if (r < 70) return random_command();
    if (r < 80) begin
      repeat ($urandom_range(20, 0)) begin
        b = 8'($urandom_range(255, 0));
        if (b == CHAR_CR || b == CHAR_LF) b = b | 8'h80;
        q.push_back(b);
      end
    end else if (r < 88) begin
      if ($urandom_range(1, 0) == 0) put_text(q, "SET:9");
      put_text(q, random_junk($urandom_range(40, 26)));
      if ($urandom_range(1, 0) == 0) put_text(q, "ALM");
    end else begin
      put_text(q, broken[$urandom_range(9, 0)]);
      put_text(q, digit_string($urandom_range(5, 0)));
    end
    q.push_back(CHAR_LF);
    return q;
  endfunction

  task automatic run_directed();
    line_t q;
    say("STS", CHAR_LF);
    say("CHK:00000", CHAR_LF);
    say("PWD:0000", CHAR_CR);
    say("SET:12345", CHAR_LF);
    say("STS", CHAR_CR);
    say("xxPWD:12345", CHAR_LF);
    say("CHK:123456", CHAR_LF);
    say("CHK:12-34y5", CHAR_LF);
    say("SET:98", CHAR_CR);
    say("CHK:98000", CHAR_LF);
    say("ALM", CHAR_LF);
    say("TMO:5", CHAR_LF);
    say("TMO:4", CHAR_LF);
    say("TMO:30", CHAR_CR);
    say("TMO:31", CHAR_LF);
    say("TMO:", CHAR_LF);
    say("TMO:99999", CHAR_LF);
    say("TMO:007", CHAR_LF);
    say("STS SET:1", CHAR_LF);
    say("ALMTMO:9", CHAR_LF);
    // A keyword split by a line end must not match.
    q = '{CHAR_S, CHAR_T, CHAR_CR, CHAR_S, CHAR_LF};
    send_line(q);
    q = '{8'h00, CHAR_S, CHAR_T, 8'h00, CHAR_S, 8'hFF, 8'h80, CHAR_LF};
    send_line(q);
    q = '{8'h00, CHAR_A, CHAR_L, CHAR_M, 8'hFF, CHAR_LF};
    send_line(q);
    // Longest line that is still decoded, then one that overflows on the LF.
    q.delete();
    put_text(q, "STS");
    repeat (LINE_LIMIT - 5) q.push_back(CHAR_D);
    q.push_back(CHAR_LF);
    send_line(q);
    q.delete();
    put_text(q, "STS");
    repeat (LINE_LIMIT - 4) q.push_back(CHAR_D);
    q.push_back(CHAR_LF);
    send_line(q);
    say("ALM", CHAR_LF);
    q.delete();
    put_text(q, "SET:55555");
    repeat (31) q.push_back(CHAR_C);
    q.push_back(CHAR_LF);
    send_line(q);
    say("CHK:98000", CHAR_LF);
    say("SET:", CHAR_LF);
    say("PWD:00000", CHAR_LF);
    quiesce();
    set_bounds(6'd0, 6'd63);
    say("TMO:0", CHAR_LF);
    say("TMO:63", CHAR_LF);
    say("TMO:64", CHAR_CR);
    say("TMO:255", CHAR_LF);
  endtask

  initial begin
    int lo_tab [PHASES];
    int hi_tab [PHASES];
    int target;
    lo_tab = '{10, 40, 0, 63, 5, 0};
    hi_tab = '{20, 12, 0, 63, 30, 63};
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_TIMEOUT_MIN;
    cfg_if.data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      if (ph == PHASES - 1)
        set_bounds(TIMEOUT_W'($urandom_range(63, 0)), TIMEOUT_W'($urandom_range(63, 0)));
      else
        set_bounds(TIMEOUT_W'(lo_tab[ph]), TIMEOUT_W'(hi_tab[ph]));
      target = chars_sent + RANDOM_CHARS / PHASES;
      while (chars_sent < target) send_line(random_line());
    end
    quiesce();
    while (sb.replies_due.size() != 0) begin
      $display("%0t ERROR missing reply: expected reply %0d, actual none",
               $time, sb.replies_due[0].reply);
      void'(sb.replies_due.pop_front());
      sb.errors++;
    end
    $display({"Sent %0d characters and checked %0d replies: ",
              "STS %0d, SET %0d, CHK %0d, PWD %0d, ALM %0d, TMO %0d"},
             chars_sent, sb.checked, sb.action_cnt[KW_STS], sb.action_cnt[KW_SET],
             sb.action_cnt[KW_CHK], sb.action_cnt[KW_PWD], sb.action_cnt[KW_ALM],
             sb.action_cnt[KW_TMO]);
    $display("%0d overlong lines dropped, %0d timeout bound settings written",
             sb.dropped_lines, bound_writes);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
rtl/plcp_pkg.sv
rtl/plcp_if.sv
rtl/plcp_line_scan.sv
rtl/plcp_action.sv
rtl/password_lock_command_parser_core.sv
test/password_lock_command_parser_core_tb.sv
